/* rtl/ray_oriented_box_slab_test_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef RAY_ORIENTED_BOX_SLAB_TEST_MACROS_SVH
`define RAY_ORIENTED_BOX_SLAB_TEST_MACROS_SVH

// Same-cycle implication.
`define ROBST_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("robst: implication check failed");

// Next-cycle implication.
`define ROBST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("robst: next-cycle check failed");

`endif

/* rtl/robst_pkg.sv */
package robst_pkg;

   localparam int COORD_W    = 20;
   localparam int AXIS_W     = 16;
   localparam int DIST_W     = 20;
   localparam int CENTER_W   = 60;
   localparam int ROW_W      = 48;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;

   localparam int REL_W  = 21;  // origin minus centre
   localparam int PROD_W = 37;  // rel * axis component
   localparam int PD_W   = 36;  // dir * axis component
   localparam int LO_W   = 39;  // box-frame origin, 24 fraction bits
   localparam int LD_W   = 38;  // box-frame direction, 24 fraction bits
   localparam int N_W    = 40;  // slab numerator before scaling
   localparam int NMAG_W = 38;  // its magnitude bound
   localparam int NUM_W  = 48;  // scaled numerator magnitude
   localparam int DEN_W  = 36;  // divisor magnitude
   localparam int QUO_W  = 34;  // quotient bits, divisor is at least 2^14
   localparam int Q_W    = 36;  // signed slab parameter

   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = QUO_W / DIV_STEPS;

   localparam int NEAR_LIMIT = 16384;
   localparam int DIST_MAX   = 1048575;

   typedef enum logic [2:0] {
      REG_BOX_CENTER   = 3'd0,
      REG_HALF_EXTENTS = 3'd1,
      REG_AXIS_ZERO    = 3'd2,
      REG_AXIS_ONE     = 3'd3,
      REG_AXIS_TWO     = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic near;
      logic near_miss;
      logic adir;
      logic neg_a;
      logic neg_b;
   } axis_flags_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] nq;
   } div_state_type;

endpackage

/* rtl/robst_req_if.sv */
interface robst_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [robst_pkg::COORD_W-1:0] origin_x;
   logic signed [robst_pkg::COORD_W-1:0] origin_y;
   logic signed [robst_pkg::COORD_W-1:0] origin_z;
   logic signed [robst_pkg::COORD_W-1:0] dir_x;
   logic signed [robst_pkg::COORD_W-1:0] dir_y;
   logic signed [robst_pkg::COORD_W-1:0] dir_z;

   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   input ready);
   modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   output ready);
endinterface

/* rtl/robst_rsp_if.sv */
interface robst_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                hit;
   logic [robst_pkg::DIST_W-1:0]        entry_distance;
   logic signed [robst_pkg::AXIS_W-1:0] normal_x;
   logic signed [robst_pkg::AXIS_W-1:0] normal_y;
   logic signed [robst_pkg::AXIS_W-1:0] normal_z;

   modport source (output valid, hit, entry_distance, normal_x, normal_y, normal_z,
                   input ready);
   modport sink   (input valid, hit, entry_distance, normal_x, normal_y, normal_z,
                   output ready);
endinterface

/* rtl/ray_oriented_box_slab_test.sv */
// Ray against one oriented box: a fully pipelined slab test of 24 register stages that takes one
// ray per cycle while no back-pressure from the result side stalls the stages. The
// depth is set by the slab dividers, two radix-2 restoring dividers per axis laid out as 17
// stages of two quotient bits each, behind a subtract, a multiply, a dot-product sum and a
// slab set-up stage, and followed by sign fix-up, slab selection and the three-axis interval
// merge. Every stage holds its own valid bit and only stalls when the stage after it is
// full, so bubbles close up under back-pressure. Box registers are read live by the later
// stages and must only be written while no ray is in flight.
`include "ray_oriented_box_slab_test_macros.svh"

module ray_oriented_box_slab_test (
   input  logic                                clock,
   input  logic                                reset,
   robst_req_if.sink                           req_port,
   robst_rsp_if.source                         rsp_port,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [robst_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [robst_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [robst_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready
);

   localparam int COORD_W    = robst_pkg::COORD_W;
   localparam int AXIS_W     = robst_pkg::AXIS_W;
   localparam int DIST_W     = robst_pkg::DIST_W;
   localparam int CENTER_W   = robst_pkg::CENTER_W;
   localparam int ROW_W      = robst_pkg::ROW_W;
   localparam int CSR_DATA_W = robst_pkg::CSR_DATA_W;
   localparam int REL_W      = robst_pkg::REL_W;
   localparam int PROD_W     = robst_pkg::PROD_W;
   localparam int PD_W       = robst_pkg::PD_W;
   localparam int LO_W       = robst_pkg::LO_W;
   localparam int LD_W       = robst_pkg::LD_W;
   localparam int N_W        = robst_pkg::N_W;
   localparam int NMAG_W     = robst_pkg::NMAG_W;
   localparam int NUM_W      = robst_pkg::NUM_W;
   localparam int DEN_W      = robst_pkg::DEN_W;
   localparam int QUO_W      = robst_pkg::QUO_W;
   localparam int Q_W        = robst_pkg::Q_W;
   localparam int DIV_STEPS  = robst_pkg::DIV_STEPS;
   localparam int DIV_STAGES = robst_pkg::DIV_STAGES;

   localparam int S_REL  = 0;
   localparam int S_PROD = 1;
   localparam int S_SUM  = 2;
   localparam int S_SET  = 3;
   localparam int S_FIX  = S_SET + DIV_STAGES + 1;
   localparam int S_SLAB = S_FIX + 1;
   localparam int S_OUT  = S_SLAB + 1;
   localparam int NSTAGE = S_OUT + 1;

   // ---------------- configuration registers ----------------
   logic [CENTER_W-1:0] center_ff;
   logic [CENTER_W-1:0] half_ff;
   logic [ROW_W-1:0]    row_ff [3];
   logic                csr_wr;
   robst_pkg::reg_index_type csr_idx;

   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = robst_pkg::reg_index_type'(paddr[5:3]);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         half_ff   <= '0;
         row_ff[0] <= 48'h0000_0000_4000;
         row_ff[1] <= 48'h0000_4000_0000;
         row_ff[2] <= 48'h4000_0000_0000;
      end else if (csr_wr) begin
         case (csr_idx)
            robst_pkg::REG_BOX_CENTER:   center_ff <= pwdata[CENTER_W-1:0];
            robst_pkg::REG_HALF_EXTENTS: half_ff   <= pwdata[CENTER_W-1:0];
            robst_pkg::REG_AXIS_ZERO:    row_ff[0] <= pwdata[ROW_W-1:0];
            robst_pkg::REG_AXIS_ONE:     row_ff[1] <= pwdata[ROW_W-1:0];
            robst_pkg::REG_AXIS_TWO:     row_ff[2] <= pwdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         robst_pkg::REG_BOX_CENTER:   prdata = CSR_DATA_W'(center_ff);
         robst_pkg::REG_HALF_EXTENTS: prdata = CSR_DATA_W'(half_ff);
         robst_pkg::REG_AXIS_ZERO:    prdata = CSR_DATA_W'(row_ff[0]);
         robst_pkg::REG_AXIS_ONE:     prdata = CSR_DATA_W'(row_ff[1]);
         robst_pkg::REG_AXIS_TWO:     prdata = CSR_DATA_W'(row_ff[2]);
         default:                     prdata = '0;
      endcase
   end

   logic signed [AXIS_W-1:0] ax [3][3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            ax[i][j] = row_ff[i][AXIS_W*j +: AXIS_W];
         end
      end
   end

   // ---------------- stage handshake ----------------
   logic [NSTAGE-1:0] v_ff;
   logic [NSTAGE-1:0] en;

   always_comb begin
      en[NSTAGE-1] = !v_ff[NSTAGE-1] || rsp_port.ready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_port.ready = en[S_REL];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= req_port.valid;
         for (int k = 1; k < NSTAGE; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   // ---------------- relative origin ----------------
   logic signed [COORD_W-1:0] org_in [3];
   logic signed [COORD_W-1:0] dir_in [3];
   logic signed [REL_W-1:0]   rel_ff [3];
   logic signed [COORD_W-1:0] dir_ff [3];

   assign org_in[0] = req_port.origin_x;
   assign org_in[1] = req_port.origin_y;
   assign org_in[2] = req_port.origin_z;
   assign dir_in[0] = req_port.dir_x;
   assign dir_in[1] = req_port.dir_y;
   assign dir_in[2] = req_port.dir_z;

   always_ff @(posedge clock) begin
      if (en[S_REL]) begin
         for (int j = 0; j < 3; j++) begin
            rel_ff[j] <= REL_W'(org_in[j])
                         - REL_W'($signed(center_ff[COORD_W*j +: COORD_W]));
            dir_ff[j] <= dir_in[j];
         end
      end
   end

   // ---------------- products ----------------
   logic signed [PROD_W-1:0] po_ff [3][3];
   logic signed [PD_W-1:0]   pd_ff [3][3];

   always_ff @(posedge clock) begin
      if (en[S_PROD]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               po_ff[i][j] <= PROD_W'(rel_ff[j]) * PROD_W'(ax[i][j]);
               pd_ff[i][j] <= PD_W'(dir_ff[j]) * PD_W'(ax[i][j]);
            end
         end
      end
   end

   // ---------------- dot-product sums ----------------
   logic signed [LO_W-1:0] lo_ff [3];
   logic signed [LD_W-1:0] ld_ff [3];

   always_ff @(posedge clock) begin
      if (en[S_SUM]) begin
         for (int i = 0; i < 3; i++) begin
            lo_ff[i] <= LO_W'(po_ff[i][0]) + LO_W'(po_ff[i][1]) + LO_W'(po_ff[i][2]);
            ld_ff[i] <= LD_W'(pd_ff[i][0]) + LD_W'(pd_ff[i][1]) + LD_W'(pd_ff[i][2]);
         end
      end
   end

   // ---------------- slab set-up and divider pipeline ----------------
   robst_pkg::div_state_type  ds_ff [DIV_STAGES+1][3][2];
   logic [DEN_W-1:0]          dd_ff [DIV_STAGES+1][3];
   robst_pkg::axis_flags_type af_ff [DIV_STAGES+1][3];

   robst_pkg::div_state_type  ds_init [3][2];
   logic [DEN_W-1:0]          dd_init [3];
   robst_pkg::axis_flags_type af_init [3];

   always_comb begin
      logic signed [N_W-1:0] hsx;
      logic signed [N_W-1:0] lox;
      logic signed [N_W-1:0] n1;
      logic signed [N_W-1:0] n2;
      logic [LD_W-1:0]       mag;
      logic                  ldneg;
      logic                  ldpos;
      logic [NMAG_W-1:0]     a1;
      logic [NMAG_W-1:0]     a2;
      logic [NUM_W-1:0]      num1;
      logic [NUM_W-1:0]      num2;
      for (int i = 0; i < 3; i++) begin
         hsx   = N_W'($signed({1'b0, half_ff[COORD_W*i +: COORD_W], 14'b0}));
         lox   = N_W'(lo_ff[i]);
         n1    = lox - hsx;
         n2    = lox + hsx;
         ldneg = ld_ff[i][LD_W-1];
         ldpos = !ldneg && (ld_ff[i] != '0);
         mag   = ldneg ? LD_W'(-ld_ff[i]) : LD_W'(ld_ff[i]);
         a1    = n1[N_W-1] ? NMAG_W'(-n1) : NMAG_W'(n1);
         a2    = n2[N_W-1] ? NMAG_W'(-n2) : NMAG_W'(n2);
         num1  = {a1, 10'b0};
         num2  = {a2, 10'b0};
         af_init[i].near      = mag < LD_W'(robst_pkg::NEAR_LIMIT);
         af_init[i].near_miss = (lox < -hsx) || (lox > hsx);
         af_init[i].adir      = ldneg && (half_ff[COORD_W*i +: COORD_W] != '0);
         af_init[i].neg_a     = n1[N_W-1] ^ ldpos;
         af_init[i].neg_b     = n2[N_W-1] ^ ldpos;
         dd_init[i]           = mag[DEN_W-1:0];
         // top numerator bits sit below the divisor, so start with them as remainder
         ds_init[i][0].rem    = DEN_W'(num1[NUM_W-1:QUO_W]);
         ds_init[i][0].nq     = num1[QUO_W-1:0];
         ds_init[i][1].rem    = DEN_W'(num2[NUM_W-1:QUO_W]);
         ds_init[i][1].nq     = num2[QUO_W-1:0];
      end
   end

   function automatic robst_pkg::div_state_type div_step(
      input robst_pkg::div_state_type s,
      input logic [DEN_W-1:0]         d
   );
      logic [DEN_W:0]           t;
      robst_pkg::div_state_type r;
      t    = {s.rem, s.nq[QUO_W-1]};
      r.nq = {s.nq[QUO_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
         r.rem   = DEN_W'(t - {1'b0, d});
         r.nq[0] = 1'b1;
      end else begin
         r.rem = t[DEN_W-1:0];
      end
      return r;
   endfunction

   robst_pkg::div_state_type ds_next [DIV_STAGES+1][3][2];

   always_comb begin
      robst_pkg::div_state_type t;
      for (int i = 0; i < 3; i++) begin
         for (int b = 0; b < 2; b++) begin
            ds_next[0][i][b] = ds_init[i][b];
            for (int s = 1; s <= DIV_STAGES; s++) begin
               t = ds_ff[s-1][i][b];
               for (int n = 0; n < DIV_STEPS; n++) begin
                  t = div_step(t, dd_ff[s-1][i]);
               end
               ds_next[s][i][b] = t;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_SET]) begin
         ds_ff[0] <= ds_next[0];
         dd_ff[0] <= dd_init;
         af_ff[0] <= af_init;
      end
      for (int s = 1; s <= DIV_STAGES; s++) begin
         if (en[S_SET+s]) begin
            ds_ff[s] <= ds_next[s];
            dd_ff[s] <= dd_ff[s-1];
            af_ff[s] <= af_ff[s-1];
         end
      end
   end

   // ---------------- floor fix-up ----------------
   logic signed [Q_W-1:0]     dq_ff [3][2];
   robst_pkg::axis_flags_type fx_af_ff [3];

   always_ff @(posedge clock) begin
      logic                  ng;
      logic [QUO_W-1:0]      q;
      logic                  inexact;
      if (en[S_FIX]) begin
         for (int i = 0; i < 3; i++) begin
            for (int b = 0; b < 2; b++) begin
               q       = ds_ff[DIV_STAGES][i][b].nq;
               inexact = ds_ff[DIV_STAGES][i][b].rem != '0;
               ng      = (b == 0) ? af_ff[DIV_STAGES][i].neg_a : af_ff[DIV_STAGES][i].neg_b;
               dq_ff[i][b] <= ng ? -(Q_W'(q) + Q_W'(inexact)) : Q_W'(q);
            end
            fx_af_ff[i] <= af_ff[DIV_STAGES][i];
         end
      end
   end

   // ---------------- per-axis slab bounds ----------------
   logic signed [Q_W-1:0] smin_ff [3];
   logic signed [Q_W-1:0] smax_ff [3];
   logic [2:0]            skip_ff;
   logic [2:0]            amiss_ff;
   logic [2:0]            adir_ff;

   always_ff @(posedge clock) begin
      logic signed [Q_W-1:0] dmin;
      logic signed [Q_W-1:0] dmax;
      if (en[S_SLAB]) begin
         for (int i = 0; i < 3; i++) begin
            dmin = fx_af_ff[i].adir ? dq_ff[i][0] : dq_ff[i][1];
            dmax = fx_af_ff[i].adir ? dq_ff[i][1] : dq_ff[i][0];
            smin_ff[i]  <= dmin[Q_W-1] ? '0 : dmin;
            smax_ff[i]  <= dmax;
            skip_ff[i]  <= fx_af_ff[i].near;
            amiss_ff[i] <= fx_af_ff[i].near ? fx_af_ff[i].near_miss : dmax[Q_W-1];
            adir_ff[i]  <= fx_af_ff[i].adir;
         end
      end
   end

   // ---------------- interval merge and result ----------------
   logic                     hit_ff;
   logic [DIST_W-1:0]        dist_ff;
   logic signed [AXIS_W-1:0] nrm_ff [3];

   always_ff @(posedge clock) begin
      logic signed [Q_W-1:0]    tmin;
      logic signed [Q_W-1:0]    tmax;
      logic                     miss;
      logic [1:0]               axis;
      logic                     sneg;
      logic signed [AXIS_W-1:0] c;
      if (en[S_OUT]) begin
         tmin = '0;
         tmax = {1'b0, {(Q_W-1){1'b1}}};
         miss = 1'b0;
         axis = 2'd0;
         sneg = 1'b0;
         for (int i = 0; i < 3; i++) begin
            if (amiss_ff[i]) miss = 1'b1;
            if (!skip_ff[i]) begin
               if (smin_ff[i] > tmin) begin
                  tmin = smin_ff[i];
                  axis = 2'(i);
                  sneg = !adir_ff[i];
               end
               if (smax_ff[i] < tmax) tmax = smax_ff[i];
               if (tmin > tmax) miss = 1'b1;
            end
         end
         hit_ff <= !miss;
         if (miss) begin
            dist_ff <= '0;
         end else if (tmin > Q_W'(robst_pkg::DIST_MAX)) begin
            dist_ff <= DIST_W'(robst_pkg::DIST_MAX);
         end else begin
            dist_ff <= tmin[DIST_W-1:0];
         end
         for (int j = 0; j < 3; j++) begin
            c = ax[axis][j];
            if (miss) begin
               nrm_ff[j] <= '0;
            end else if (!sneg) begin
               nrm_ff[j] <= c;
            end else if (c == {1'b1, {(AXIS_W-1){1'b0}}}) begin
               nrm_ff[j] <= {1'b0, {(AXIS_W-1){1'b1}}};
            end else begin
               nrm_ff[j] <= -c;
            end
         end
      end
   end

   assign rsp_port.valid          = v_ff[S_OUT];
   assign rsp_port.hit            = hit_ff;
   assign rsp_port.entry_distance = dist_ff;
   assign rsp_port.normal_x       = nrm_ff[0];
   assign rsp_port.normal_y       = nrm_ff[1];
   assign rsp_port.normal_z       = nrm_ff[2];

   // ---------------- assertions ----------------
   `ROBST_ASSERT_IMPL(a_miss_zero, clock, reset, rsp_port.valid && !rsp_port.hit,
      rsp_port.entry_distance == '0 && rsp_port.normal_x == '0
      && rsp_port.normal_y == '0 && rsp_port.normal_z == '0)
   `ROBST_ASSERT_NEXT(a_accept_enters, clock, reset, req_port.valid && req_port.ready,
      v_ff[S_REL])
   `ROBST_ASSERT_IMPL(a_ready_blocked, clock, reset, !req_port.ready,
      rsp_port.valid && !rsp_port.ready)
   `ROBST_ASSERT_NEXT(a_fix_holds, clock, reset, v_ff[S_FIX] && !en[S_FIX], v_ff[S_FIX])

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

   localparam int LIMIT_CYCLES = 300000;
   localparam int DRAIN_CYCLES = 40;
   localparam int ITEMS_PER_SETTING = 105;

   typedef struct {
      logic signed [robst_pkg::COORD_W-1:0] org[3];
      logic signed [robst_pkg::COORD_W-1:0] dir[3];
   } ray_type;

   typedef struct {
      bit                                hit;
      bit [robst_pkg::DIST_W-1:0]        distance;
      bit signed [robst_pkg::AXIS_W-1:0] nrm[3];
   } slab_hit_type;

   typedef struct {
      ray_type      ray;
      bit           known;
      slab_hit_type want;
   } stim_row_type;

   typedef struct {
      bit [robst_pkg::CENTER_W-1:0] centre;
      bit [robst_pkg::CENTER_W-1:0] half;
      bit [robst_pkg::ROW_W-1:0]    row[3];
   } box_type;

   logic clock = 0;
   logic reset = 1;

   robst_req_if req_bus();
   robst_rsp_if rsp_bus();

   logic                             csr_psel = 0;
   logic                             csr_penable = 0;
   logic                             csr_pwrite = 0;
   logic [robst_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [robst_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [robst_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                             csr_pready;

   ray_oriented_box_slab_test DUT (
      .clock(clock), .reset(reset),
      .req_port(req_bus), .rsp_port(rsp_bus),
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata), .pready(csr_pready)
   );

   // shadow of the box registers
   box_type      box_cfg;
   slab_hit_type pending_hits[$];
   int           fail_count = 0;
   int           cycle_count = 0;
   bit           quiet_sender = 0;
   bit           quiet_receiver = 0;
   bit           hold_req = 0;
   int           hold_left = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   initial begin
      req_bus.valid = 0;
      req_bus.origin_x = '0; req_bus.origin_y = '0; req_bus.origin_z = '0;
      req_bus.dir_x = '0; req_bus.dir_y = '0; req_bus.dir_z = '0;
      rsp_bus.ready = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("ray_oriented_box_slab_test verification failed");
         $finish;
      end
   end

   function automatic longint floor_q(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q -= 1;
      return q;
   endfunction

   function automatic slab_hit_type predict_slab(ray_type r);
      longint       rel[3], dv[3], hx[3], ax[3][3], lo[3], ld[3];
      longint       tmin, tmax, den, n1, n2, d1, d2, dmin, dmax, mag, v, side, adir;
      int           axis_sel;
      slab_hit_type res;
      res.hit = 0; res.distance = '0;
      foreach (res.nrm[j]) res.nrm[j] = '0;
      tmin = 0; tmax = 64'h7fff_ffff_ffff_ffff; axis_sel = 0; side = 1;
      for (int j = 0; j < 3; j++) begin
         rel[j] = longint'(r.org[j]) - longint'($signed(box_cfg.centre[20*j +: 20]));
         dv[j]  = longint'(r.dir[j]);
         hx[j]  = longint'({1'b0, box_cfg.half[20*j +: 20]}) * 16384;
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            ax[i][j] = longint'($signed(box_cfg.row[i][16*j +: 16]));
      for (int i = 0; i < 3; i++) begin
         lo[i] = 0; ld[i] = 0;
         for (int j = 0; j < 3; j++) begin
            lo[i] += rel[j] * ax[i][j];
            ld[i] += dv[j] * ax[i][j];
         end
      end
      for (int i = 0; i < 3; i++) begin
         mag = ld[i] < 0 ? -ld[i] : ld[i];
         if (mag < robst_pkg::NEAR_LIMIT) begin
            if (lo[i] < -hx[i] || lo[i] > hx[i]) return res;
            continue;
         end
         den = -ld[i];
         n1 = lo[i] - hx[i];
         n2 = lo[i] + hx[i];
         if (den < 0) begin
            d1 = floor_q(-n1 * 1024, -den);
            d2 = floor_q(-n2 * 1024, -den);
         end else begin
            d1 = floor_q(n1 * 1024, den);
            d2 = floor_q(n2 * 1024, den);
         end
         if (den > 0 && hx[i] > 0) begin
            dmin = d1; dmax = d2; adir = 1;
         end else begin
            dmin = d2; dmax = d1; adir = -1;
         end
         if (dmax < 0) return res;
         if (dmin < 0) dmin = 0;
         if (dmin > tmin) begin
            tmin = dmin; axis_sel = i; side = adir;
         end
         if (dmax < tmax) tmax = dmax;
         if (tmin > tmax) return res;
      end
      for (int j = 0; j < 3; j++) begin
         v = ax[axis_sel][j] * side;
         if (v > 32767) v = 32767;
         res.nrm[j] = v[15:0];
      end
      if (tmin > robst_pkg::DIST_MAX) tmin = robst_pkg::DIST_MAX;
      res.hit = 1;
      res.distance = tmin[19:0];
      return res;
   endfunction

   // result side: random back-pressure plus one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 0;
      end else if (hold_req) begin
         hold_req <= 0;
         hold_left <= 400;
         rsp_bus.ready <= 0;
      end else if (quiet_receiver) begin
         rsp_bus.ready <= 1;
      end else if ($urandom_range(0, 99) < 3) begin
         hold_left <= $urandom_range(10, 50);
         rsp_bus.ready <= 0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // signals are stable at the falling edge; the transaction lands at the next rising edge
   always @(negedge clock) begin
      slab_hit_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_hits.size() == 0) begin
            $error("result transaction with nothing expected");
            fail_count++;
         end else begin
            want = pending_hits.pop_front();
            if (rsp_bus.hit !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_bus.hit);
               fail_count++;
            end
            if (rsp_bus.entry_distance !== want.distance) begin
               $error("entry_distance: expected %0d, got %0d", want.distance,
                      rsp_bus.entry_distance);
               fail_count++;
            end
            if (rsp_bus.normal_x !== want.nrm[0]) begin
               $error("normal_x: expected %0d, got %0d", want.nrm[0], rsp_bus.normal_x);
               fail_count++;
            end
            if (rsp_bus.normal_y !== want.nrm[1]) begin
               $error("normal_y: expected %0d, got %0d", want.nrm[1], rsp_bus.normal_y);
               fail_count++;
            end
            if (rsp_bus.normal_z !== want.nrm[2]) begin
               $error("normal_z: expected %0d, got %0d", want.nrm[2], rsp_bus.normal_z);
               fail_count++;
            end
         end
      end
   end

   task automatic write_reg(robst_pkg::reg_index_type idx,
                            logic [robst_pkg::CSR_DATA_W-1:0] val);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= robst_pkg::CSR_ADDR_W'(idx * 8);
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (idx)
         robst_pkg::REG_BOX_CENTER:   box_cfg.centre = val[robst_pkg::CENTER_W-1:0];
         robst_pkg::REG_HALF_EXTENTS: box_cfg.half   = val[robst_pkg::CENTER_W-1:0];
         robst_pkg::REG_AXIS_ZERO:    box_cfg.row[0] = val[robst_pkg::ROW_W-1:0];
         robst_pkg::REG_AXIS_ONE:     box_cfg.row[1] = val[robst_pkg::ROW_W-1:0];
         robst_pkg::REG_AXIS_TWO:     box_cfg.row[2] = val[robst_pkg::ROW_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_box(box_type b);
      wait_drained();
      write_reg(robst_pkg::REG_BOX_CENTER, 64'(b.centre));
      write_reg(robst_pkg::REG_HALF_EXTENTS, 64'(b.half));
      write_reg(robst_pkg::REG_AXIS_ZERO, 64'(b.row[0]));
      write_reg(robst_pkg::REG_AXIS_ONE, 64'(b.row[1]));
      write_reg(robst_pkg::REG_AXIS_TWO, 64'(b.row[2]));
   endtask

   task automatic send_ray(ray_type r, bit known, slab_hit_type want);
      bit           took;
      int           gap;
      int           pick;
      slab_hit_type p;
      req_bus.valid <= 1;
      req_bus.origin_x <= r.org[0]; req_bus.origin_y <= r.org[1];
      req_bus.origin_z <= r.org[2];
      req_bus.dir_x <= r.dir[0]; req_bus.dir_y <= r.dir[1]; req_bus.dir_z <= r.dir[2];
      do begin
         @(negedge clock);
         took = req_bus.ready;
         @(posedge clock);
      end while (!took);
      p = predict_slab(r);
      pending_hits.push_back(known ? want : p);
      pick = $urandom_range(0, 99);
      gap = quiet_sender ? 0 : pick < 65 ? 0 : pick < 95 ? $urandom_range(1, 3)
                                                          : $urandom_range(8, 40);
      if (gap > 0) begin
         req_bus.valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic ray_type rand_ray();
      ray_type r;
      int      kind, c, o, t;
      kind = $urandom_range(0, 9);
      for (int j = 0; j < 3; j++) begin
         c = $signed(box_cfg.centre[20*j +: 20]);
         if (kind < 2) begin
            r.org[j] = 20'($urandom);
            r.dir[j] = 20'($urandom);
         end else if (kind == 2) begin
            r.org[j] = 20'(c + $urandom_range(0, 4000) - 2000);
            r.dir[j] = 20'($urandom_range(0, 4) - 2);
         end else begin
            o = c + $urandom_range(0, 20000) - 10000;
            t = c + $urandom_range(0, 2000) - 1000;
            r.org[j] = 20'(o);
            r.dir[j] = 20'((t - o) / int'($urandom_range(1, 16)));
         end
      end
      return r;
   endfunction

   function automatic ray_type mk_ray(int ox, int oy, int oz, int dx, int dy, int dz);
      ray_type r;
      r.org[0] = 20'(ox); r.org[1] = 20'(oy); r.org[2] = 20'(oz);
      r.dir[0] = 20'(dx); r.dir[1] = 20'(dy); r.dir[2] = 20'(dz);
      return r;
   endfunction

   function automatic slab_hit_type mk_hit(bit h, int d, int nx, int ny, int nz);
      slab_hit_type s;
      s.hit = h; s.distance = 20'(d);
      s.nrm[0] = 16'(nx); s.nrm[1] = 16'(ny); s.nrm[2] = 16'(nz);
      return s;
   endfunction

   initial begin
      stim_row_type reset_rows[$];
      stim_row_type unit_rows[$];
      box_type      boxes[$];
      box_type      b;
      slab_hit_type none;

      none = mk_hit(0, 0, 0, 0, 0);
      // reset box: zero size at the origin, identity axes
      reset_rows.push_back('{mk_ray(0, 0, 0, 0, 0, 0), 1, mk_hit(1, 0, 16384, 0, 0)});
      reset_rows.push_back('{mk_ray(1024, 0, 0, 0, 0, 0), 1, none});
      reset_rows.push_back('{mk_ray(0, 0, 0, 1024, 0, 0), 0, none});
      reset_rows.push_back('{mk_ray(524287, 524287, 524287, -524288, -524288, -524288),
                             0, none});
      reset_rows.push_back('{mk_ray(-524288, -524288, -524288, 524287, 524287, 524287),
                             0, none});
      reset_rows.push_back('{mk_ray(-1, -1, -1, 1, 1, 1), 0, none});

      // unit box, half size 1.0
      unit_rows.push_back('{mk_ray(-4096, 0, 0, 1024, 0, 0), 1, mk_hit(1, 3072, -16384, 0, 0)});
      unit_rows.push_back('{mk_ray(4096, 0, 0, 1024, 0, 0), 1, none});
      unit_rows.push_back('{mk_ray(0, 4096, 0, 1024, 0, 0), 1, none});
      unit_rows.push_back('{mk_ray(0, 0, 0, 1024, 0, 0), 1, mk_hit(1, 0, 16384, 0, 0)});
      unit_rows.push_back('{mk_ray(0, 0, 0, 0, 0, 0), 1, mk_hit(1, 0, 16384, 0, 0)});
      unit_rows.push_back('{mk_ray(-4096, -4096, 0, 1024, 4096, 0), 0, none});
      unit_rows.push_back('{mk_ray(0, 0, 4096, 0, 0, -1024), 0, none});
      unit_rows.push_back('{mk_ray(-524288, 0, 0, 16, 0, 0), 0, none});
      unit_rows.push_back('{mk_ray(-524288, 0, 0, 1, 0, 0), 0, none});
      unit_rows.push_back('{mk_ray(3000, -3000, 3000, -1000, 1000, -1000), 0, none});
      unit_rows.push_back('{mk_ray(524287, 0, 0, -524288, 0, 0), 0, none});

      b.centre = '0; b.half = {20'd1024, 20'd1024, 20'd1024};
      b.row[0] = 48'h0000_0000_4000; b.row[1] = 48'h0000_4000_0000;
      b.row[2] = 48'h4000_0000_0000;
      boxes.push_back(b);
      b.centre = {20'd512, -20'sd1024, 20'd2048}; b.half = {20'd3000, 20'd512, 20'd2048};
      b.row[0] = {16'd0, 16'd11585, 16'd11585}; b.row[1] = {16'd0, 16'd11585, -16'sd11585};
      b.row[2] = {16'd16384, 16'd0, 16'd0};
      boxes.push_back(b);
      b.centre = '1; b.half = '1; b.row[0] = '1; b.row[1] = '1; b.row[2] = '1;
      boxes.push_back(b);
      b.centre = '0; b.half = '0; b.row[0] = '0; b.row[1] = '0; b.row[2] = '0;
      boxes.push_back(b);
      b.centre = {20'h00000, 20'h80000, 20'h7ffff}; b.half = {20'd4096, 20'd4096, 20'd4096};
      b.row[0] = {16'h0000, 16'h7fff, 16'h8000}; b.row[1] = {16'h0000, 16'h8000, 16'h0000};
      b.row[2] = {16'h8000, 16'h0000, 16'h0000};
      boxes.push_back(b);
      b.centre = robst_pkg::CENTER_W'({$urandom, $urandom});
      b.half   = robst_pkg::CENTER_W'({$urandom, $urandom});
      b.row[0] = robst_pkg::ROW_W'({$urandom, $urandom});
      b.row[1] = robst_pkg::ROW_W'({$urandom, $urandom});
      b.row[2] = robst_pkg::ROW_W'({$urandom, $urandom});
      boxes.push_back(b);
      b.centre = {20'd10, -20'sd20, 20'd300}; b.half = {20'd100, 20'd2, 20'd50000};
      b.row[0] = {16'd0, 16'd9459, 16'd13377}; b.row[1] = {16'd0, -16'sd13377, 16'd9459};
      b.row[2] = {16'd16384, 16'd0, 16'd0};
      boxes.push_back(b);

      box_cfg.centre = '0; box_cfg.half = '0;
      box_cfg.row[0] = 48'h0000_0000_4000; box_cfg.row[1] = 48'h0000_4000_0000;
      box_cfg.row[2] = 48'h4000_0000_0000;

      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (reset_rows[k]) send_ray(reset_rows[k].ray, reset_rows[k].known,
                                       reset_rows[k].want);
      req_bus.valid <= 0;
      load_box(boxes[0]);
      foreach (unit_rows[k]) send_ray(unit_rows[k].ray, unit_rows[k].known,
                                      unit_rows[k].want);
      req_bus.valid <= 0;

      foreach (boxes[p]) begin
         load_box(boxes[p]);
         quiet_sender = (p % 3 == 1);
         quiet_receiver = (p % 4 == 3);
         if (p == 1) begin
            quiet_sender = 1;
            hold_req = 1;
         end
         for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
            if (p == 2 && n == 50) begin
               // sender waits for the pipe to empty completely
               req_bus.valid <= 0;
               while (pending_hits.size() != 0) @(posedge clock);
            end
            send_ray(rand_ray(), 0, none);
         end
         req_bus.valid <= 0;
      end

      wait_drained();
      if (fail_count == 0)
         $display("ray_oriented_box_slab_test verification clean");
      else
         $display("ray_oriented_box_slab_test verification failed");
      $finish;
   end

endmodule

/* ray_oriented_box_slab_test.f */
+incdir+rtl
rtl/robst_pkg.sv
rtl/robst_req_if.sv
rtl/robst_rsp_if.sv
rtl/ray_oriented_box_slab_test.sv
bench/tb.sv
